### hdl/spring_force_2d_macros.svh
// Assertion macros for the spring force block.
`ifndef SPRING_FORCE_2D_MACROS_SVH
`define SPRING_FORCE_2D_MACROS_SVH

// Same-cycle implication.
`define SF2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SF2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/sf2d_pkg.sv
`timescale 1ns / 1ps
package sf2d_pkg;

  localparam int unsigned XW  = 32;  // port word
  localparam int unsigned DW  = 33;  // end-to-end difference magnitude
  localparam int unsigned SQW = 66;  // square of a difference
  localparam int unsigned RW  = 68;  // root remainder
  localparam int unsigned LW  = 34;  // length (root) bits
  localparam int unsigned SPW = 2 * XW + 2 * DW;  // payload through the root chain

  typedef struct packed {
    logic vld;
    logic deg;
    logic sneg;
    logic sx;
    logic sy;
  } sf2d_ctl_t;

endpackage

### hdl/sf2d_sqrt_cell.sv
`timescale 1ns / 1ps
module sf2d_sqrt_cell #(
  parameter int unsigned BIT = 0,
  parameter int unsigned PW  = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sf2d_pkg::sf2d_ctl_t        ctl_i,
  input  logic [sf2d_pkg::RW-1:0]    rem_i,
  input  logic [sf2d_pkg::LW-1:0]    root_i,
  input  logic [PW-1:0]              pay_i,
  output sf2d_pkg::sf2d_ctl_t        ctl_o,
  output logic [sf2d_pkg::RW-1:0]    rem_o,
  output logic [sf2d_pkg::LW-1:0]    root_o,
  output logic [PW-1:0]              pay_o
);
  import sf2d_pkg::*;

  logic [RW-1:0] trial;
  logic          ge;
  sf2d_ctl_t     ctl_q;
  logic [RW-1:0] rem_q, rem_d;
  logic [LW-1:0] root_q, root_d;
  logic [PW-1:0] pay_q;

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  always_comb begin
    trial  = (RW'(root_i) << (BIT + 1)) + (RW'(1) << (2 * BIT));
    ge     = rem_i >= trial;
    rem_d  = ge ? rem_i - trial : rem_i;
    root_d = ge ? (root_i | (LW'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    pay_q  <= pay_i;
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign pay_o  = pay_q;

endmodule

### hdl/sf2d_div_cell.sv
`timescale 1ns / 1ps
module sf2d_div_cell #(
  parameter int unsigned BIT = 0,
  parameter int unsigned NW  = 51,
  parameter int unsigned QW  = 17,
  parameter int unsigned PW  = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sf2d_pkg::sf2d_ctl_t     ctl_i,
  input  logic [sf2d_pkg::LW-1:0] den_i,
  input  logic [NW-1:0]           rx_i,
  input  logic [NW-1:0]           ry_i,
  input  logic [QW-1:0]           qx_i,
  input  logic [QW-1:0]           qy_i,
  input  logic [PW-1:0]           pay_i,
  output sf2d_pkg::sf2d_ctl_t     ctl_o,
  output logic [sf2d_pkg::LW-1:0] den_o,
  output logic [NW-1:0]           rx_o,
  output logic [NW-1:0]           ry_o,
  output logic [QW-1:0]           qx_o,
  output logic [QW-1:0]           qy_o,
  output logic [PW-1:0]           pay_o
);
  import sf2d_pkg::*;

  logic [NW-1:0] trial;
  logic          gex, gey;
  sf2d_ctl_t     ctl_q;
  logic [LW-1:0] den_q;
  logic [NW-1:0] rx_q, ry_q;
  logic [QW-1:0] qx_q, qy_q;
  logic [PW-1:0] pay_q;

  always_comb begin
    trial = NW'(den_i) << BIT;
    gex   = rx_i >= trial;
    gey   = ry_i >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_i;
    rx_q  <= gex ? rx_i - trial : rx_i;
    ry_q  <= gey ? ry_i - trial : ry_i;
    qx_q  <= qx_i | (QW'(gex) << BIT);
    qy_q  <= qy_i | (QW'(gey) << BIT);
    pay_q <= pay_i;
  end

  assign ctl_o = ctl_q;
  assign den_o = den_q;
  assign rx_o  = rx_q;
  assign ry_o  = ry_q;
  assign qx_o  = qx_q;
  assign qy_o  = qy_q;
  assign pay_o = pay_q;

endmodule

### hdl/spring_force_2d.sv
`timescale 1ns / 1ps
// Hooke spring force on the first end of a 2D spring, fixed point with FRAC_BITS
// fraction bits. A spring is taken on any cycle with start high; busy stays low, so
// one spring per cycle is accepted. Each result leaves FRAC_BITS + 42 cycles later
// (58 at Q16.16) as a one-cycle done_o beat that cannot be held off, so the
// receiver must take every beat. The latency is set by the 34-cell square root row
// and the FRAC_BITS + 1 cell divider row for the unit vector.
module spring_force_2d #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] first_x_i,
  input  logic signed [31:0] first_y_i,
  input  logic signed [31:0] second_x_i,
  input  logic signed [31:0] second_y_i,
  input  logic        [31:0] rest_length_i,
  input  logic        [31:0] stiffness_i,
  output logic               done_o,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic               saturated_o,
  output logic               degenerate_o
);
  import sf2d_pkg::*;
  `include "spring_force_2d_macros.svh"

  localparam int unsigned FW = 66 - FRAC_BITS;      // factor width
  localparam int unsigned QW = FRAC_BITS + 1;       // unit vector component
  localparam int unsigned NW = LW + FRAC_BITS + 1;  // divider remainder
  localparam int unsigned MW = FW + QW;

  // stage 1: differences
  logic [DW-1:0] dx, dy, dxm, dym;
  sf2d_ctl_t     c1_d, c1_q, c2_q, c3_q, ca_q, ca_d, cb_q, cc_q;
  logic [SPW-1:0] p1_q, p2_q, p3_q;
  logic [DW-1:0] dxm1_q, dym1_q;
  logic [SQW-1:0] sqx2_q, sqy2_q;
  logic [RW-1:0] sum3_q;

  always_comb begin
    dx   = {second_x_i[31], second_x_i} - {first_x_i[31], first_x_i};
    dy   = {second_y_i[31], second_y_i} - {first_y_i[31], first_y_i};
    dxm  = dx[DW-1] ? (~dx + DW'(1)) : dx;
    dym  = dy[DW-1] ? (~dy + DW'(1)) : dy;
    c1_d = '{vld: start && !busy, deg: (dx == '0) && (dy == '0), sneg: 1'b0,
             sx: dx[DW-1], sy: dy[DW-1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
    end else begin
      c1_q <= c1_d;
      c2_q <= c1_q;
      c3_q <= c2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dxm1_q <= dxm;
    dym1_q <= dym;
    p1_q   <= {rest_length_i, stiffness_i, dxm, dym};
    sqx2_q <= SQW'(dxm1_q) * SQW'(dxm1_q);
    sqy2_q <= SQW'(dym1_q) * SQW'(dym1_q);
    p2_q   <= p1_q;
    sum3_q <= RW'(sqx2_q) + RW'(sqy2_q);
    p3_q   <= p2_q;
  end

  // square root row
  sf2d_ctl_t      sq_ctl  [0:LW];
  logic [RW-1:0]  sq_rem  [0:LW];
  logic [LW-1:0]  sq_root [0:LW];
  logic [SPW-1:0] sq_pay  [0:LW];

  assign sq_ctl[0]  = c3_q;
  assign sq_rem[0]  = sum3_q;
  assign sq_root[0] = '0;
  assign sq_pay[0]  = p3_q;

  for (genvar i = 0; i < LW; i++) begin : g_sqrt
    sf2d_sqrt_cell #(.BIT(LW - 1 - i), .PW(SPW)) u_cell (
      .clk_i, .rst_ni,
      .ctl_i(sq_ctl[i]), .rem_i(sq_rem[i]), .root_i(sq_root[i]), .pay_i(sq_pay[i]),
      .ctl_o(sq_ctl[i+1]), .rem_o(sq_rem[i+1]), .root_o(sq_root[i+1]),
      .pay_o(sq_pay[i+1])
    );
  end

  // stage A: stretch
  logic [XW-1:0]   rest_s, k_s;
  logic [DW-1:0]   dxm_s, dym_s;
  logic [LW:0]     sdiff;
  logic [LW-1:0]   smag, smag_a_q, len_a_q, len_b_q;
  logic [XW-1:0]   k_a_q;
  logic [DW-1:0]   dxm_a_q, dym_a_q, dxm_b_q, dym_b_q;
  logic [FW-1:0]   fac_b_q;
  logic [SQW-1:0]  kprod;

  always_comb begin
    {rest_s, k_s, dxm_s, dym_s} = sq_pay[LW];
    sdiff = {1'b0, sq_root[LW]} - (LW+1)'(rest_s);
    smag  = sdiff[LW] ? LW'(~sdiff + (LW+1)'(1)) : sdiff[LW-1:0];
    ca_d  = sq_ctl[LW];
    ca_d.sneg = sdiff[LW];
    kprod = SQW'(k_a_q) * SQW'(smag_a_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ca_q <= '0;
      cb_q <= '0;
    end else begin
      ca_q <= ca_d;
      cb_q <= ca_q;
    end
  end

  always_ff @(posedge clk_i) begin
    smag_a_q <= smag;
    len_a_q  <= sq_root[LW];
    k_a_q    <= k_s;
    dxm_a_q  <= dxm_s;
    dym_a_q  <= dym_s;
    fac_b_q  <= FW'(kprod >> FRAC_BITS);
    len_b_q  <= len_a_q;
    dxm_b_q  <= dxm_a_q;
    dym_b_q  <= dym_a_q;
  end

  // divider row: unit vector components
  sf2d_ctl_t     dv_ctl [0:QW];
  logic [LW-1:0] dv_den [0:QW];
  logic [NW-1:0] dv_rx  [0:QW];
  logic [NW-1:0] dv_ry  [0:QW];
  logic [QW-1:0] dv_qx  [0:QW];
  logic [QW-1:0] dv_qy  [0:QW];
  logic [FW-1:0] dv_pay [0:QW];

  assign dv_ctl[0] = cb_q;
  assign dv_den[0] = len_b_q;
  assign dv_rx[0]  = NW'(dxm_b_q) << FRAC_BITS;
  assign dv_ry[0]  = NW'(dym_b_q) << FRAC_BITS;
  assign dv_qx[0]  = '0;
  assign dv_qy[0]  = '0;
  assign dv_pay[0] = fac_b_q;

  for (genvar j = 0; j < QW; j++) begin : g_div
    sf2d_div_cell #(.BIT(QW - 1 - j), .NW(NW), .QW(QW), .PW(FW)) u_cell (
      .clk_i, .rst_ni,
      .ctl_i(dv_ctl[j]), .den_i(dv_den[j]), .rx_i(dv_rx[j]), .ry_i(dv_ry[j]),
      .qx_i(dv_qx[j]), .qy_i(dv_qy[j]), .pay_i(dv_pay[j]),
      .ctl_o(dv_ctl[j+1]), .den_o(dv_den[j+1]), .rx_o(dv_rx[j+1]), .ry_o(dv_ry[j+1]),
      .qx_o(dv_qx[j+1]), .qy_o(dv_qy[j+1]), .pay_o(dv_pay[j+1])
    );
  end

  // stage C: scale, stage D: sign and clip
  logic [MW-1:0] px, py;
  logic [FW-1:0] fxm_q, fym_q;
  logic          negx, negy, satx, saty;
  logic [XW-1:0] fx_d, fy_d;
  localparam logic [FW-1:0] NegLim = FW'(64'h8000_0000);
  localparam logic [FW-1:0] PosLim = FW'(64'h7FFF_FFFF);

  always_comb begin
    px   = MW'(dv_pay[QW]) * MW'(dv_qx[QW]);
    py   = MW'(dv_pay[QW]) * MW'(dv_qy[QW]);
    negx = (fxm_q != '0) && (cc_q.sneg != cc_q.sx);
    negy = (fym_q != '0) && (cc_q.sneg != cc_q.sy);
    satx = negx ? (fxm_q > NegLim) : (fxm_q > PosLim);
    saty = negy ? (fym_q > NegLim) : (fym_q > PosLim);
    if (satx) begin
      fx_d = negx ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      fx_d = negx ? (~fxm_q[XW-1:0] + XW'(1)) : fxm_q[XW-1:0];
    end
    if (saty) begin
      fy_d = negy ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      fy_d = negy ? (~fym_q[XW-1:0] + XW'(1)) : fym_q[XW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      done_o <= 1'b0;
    end else begin
      cc_q   <= dv_ctl[QW];
      done_o <= cc_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    fxm_q        <= FW'(px >> FRAC_BITS);
    fym_q        <= FW'(py >> FRAC_BITS);
    force_x_o    <= cc_q.deg ? '0 : fx_d;
    force_y_o    <= cc_q.deg ? '0 : fy_d;
    saturated_o  <= !cc_q.deg && (satx || saty);
    degenerate_o <= cc_q.deg;
  end

  assign busy = 1'b0;

  `SF2D_ASSERT_IMP(a_deg_zero, done_o && degenerate_o,
    force_x_o == '0 && force_y_o == '0 && !saturated_o, "degenerate beat not zero")
  `SF2D_ASSERT_IMP(a_sat_rail, done_o && saturated_o,
    force_x_o == 32'sh7FFF_FFFF || force_x_o == -32'sh8000_0000 ||
    force_y_o == 32'sh7FFF_FFFF || force_y_o == -32'sh8000_0000, "saturation off rail")
  `SF2D_ASSERT_NXT(a_done_follows, cc_q.vld, done_o, "beat lost at output")
  `SF2D_ASSERT_IMP(a_root_range, sq_ctl[LW].vld, !sq_root[LW][LW-1], "root too large")
  `SF2D_ASSERT_IMP(a_unit_range, dv_ctl[QW].vld && !dv_ctl[QW].deg,
    dv_qx[QW] <= (QW'(1) << FRAC_BITS) && dv_qy[QW] <= (QW'(1) << FRAC_BITS),
    "unit component above one")

endmodule
